// ===== hdl/jfps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfps_pkg: shared types and constants of the five-point stencil
// Sample format, register map and the quarter-sum arithmetic.
// ----------------------------------------------------------------------------
package jfps_pkg;

	// signed q2.29 samples and the exact four-term sum
	localparam int DATA_W = 32;
	localparam int SUM_W  = DATA_W + 2;

	// configuration register map
	localparam int ROW_LENGTH_W = 11;
	localparam int ROW_COUNT_W  = 16;
	localparam int CFG_W        = 16;

	typedef enum logic [0:0] {
		REG_ROW_LENGTH = 1'b0,
		REG_ROW_COUNT  = 1'b1
	} reg_index_t;

	localparam int ROW_LENGTH_RST = 1024;
	localparam int ROW_COUNT_RST  = 1024;
	localparam int MIN_EXTENT     = 3;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	// floor((a + b + c + d) / 4), always fits the sample width
	function automatic sample_t quarter_sum(sample_t a, sample_t b, sample_t c, sample_t d);
		sum_t sum;
		sum = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d);
		return sum[SUM_W-1:2];
	endfunction

endpackage

// ===== hdl/jfps_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfps_sample_if: grid sample channel
// Valid/ready stream carrying one raster-order grid sample per transfer.
// ----------------------------------------------------------------------------
interface jfps_sample_if;
	logic               valid;
	logic               ready;
	jfps_pkg::sample_t  sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ===== hdl/jfps_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfps_result_if: stencil result channel
// Valid/ready stream carrying one updated interior value per transfer.
// ----------------------------------------------------------------------------
interface jfps_result_if;
	logic               valid;
	logic               ready;
	jfps_pkg::sample_t  value;
	logic               last_of_grid;

	modport source (output valid, output value, output last_of_grid, input ready);
	modport sink (input valid, input value, input last_of_grid, output ready);
endinterface

// ===== hdl/jacobi_five_point_stencil.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil: one jacobi sweep of the 2d laplace stencil
// Streams a grid in raster order and emits the four-neighbour average of
// every interior point, using two row line buffers.
// ----------------------------------------------------------------------------
// Usage
//   samples : sink channel, one grid sample per transfer in raster order,
//             boundary ring included.
//   results : source channel, one transfer per interior point in raster
//             order; last_of_grid marks the final point of the grid.
//   wr_en / wr_index / wr_data : register writes (row_length, row_count),
//             allowed only while the block is idle; any write restarts the
//             grid at row 0, column 0.
// Timing
//   One sample per cycle sustained while results are accepted. For each
//   sample, the transfer edge loads the line buffer read register, and the
//   stencil add for its result goes into the output register as the item
//   leaves the read stage. Results come from samples at row >= 2 and column >= 2 only.
// Reset and stall
//   Reset restores 1024 x 1024 (row length limited to MAX_ROW_LENGTH) and
//   position zero. Line buffers need no clearing: rows 0 and 1 of each grid
//   fill them before any read is used. A stalled receiver holds the output
//   register; one more sample waits in the read stage, then ready drops.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil #(
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	jfps_sample_if.sink                    samples,
	jfps_result_if.source                  results,
	input  logic                           wr_en,
	input  jfps_pkg::reg_index_t           wr_index,
	input  logic [jfps_pkg::CFG_W-1:0]     wr_data
);

	localparam int COL_W = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;
	localparam int LEN_RST = (jfps_pkg::ROW_LENGTH_RST > MAX_ROW_LENGTH)
		? MAX_ROW_LENGTH : jfps_pkg::ROW_LENGTH_RST;
	localparam int RW = jfps_pkg::ROW_COUNT_W;

	// effective grid extent, stored as last column / last row
	logic [COL_W-1:0] last_col_q;
	logic [RW-1:0]    last_row_q;

	// raster position of the next sample
	logic [COL_W-1:0] col_q;
	logic [RW-1:0]    row_q;

	// read stage
	logic                valid_s1;
	logic                produce_s1;
	logic                last_s1;
	logic [COL_W-1:0]    col_s1;
	jfps_pkg::sample_t   sample_s1;
	jfps_pkg::sample_t   older_rd_s1;
	jfps_pkg::sample_t   prev_rd_s1;

	// neighbour delay registers
	jfps_pkg::sample_t   north_q;
	jfps_pkg::sample_t   south_q;
	jfps_pkg::sample_t   mid1_q;
	jfps_pkg::sample_t   mid2_q;

	// output register
	logic                out_valid_q;
	jfps_pkg::sample_t   value_q;
	logic                last_q;

	// line buffers: rows r-2 and r-1
	jfps_pkg::sample_t   older_mem [MAX_ROW_LENGTH];
	jfps_pkg::sample_t   prev_mem  [MAX_ROW_LENGTH];

	logic                accept;
	logic                advance_s1;
	logic                col_wrap;
	logic [jfps_pkg::ROW_LENGTH_W-1:0] len_raw;
	logic [RW-1:0]       cnt_raw;
	logic [COL_W-1:0]    last_col_new;
	logic [RW-1:0]       last_row_new;

	// handshake
	assign advance_s1 = valid_s1 && (!produce_s1 || !out_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance_s1;
	assign accept = samples.valid && samples.ready;
	assign col_wrap = (col_q == last_col_q);

	// clamp written extents
	always_comb begin
		len_raw = wr_data[jfps_pkg::ROW_LENGTH_W-1:0];
		cnt_raw = wr_data[RW-1:0];
		if (32'(len_raw) < 32'(jfps_pkg::MIN_EXTENT)) begin
			last_col_new = COL_W'(jfps_pkg::MIN_EXTENT - 1);
		end else if (32'(len_raw) > 32'(MAX_ROW_LENGTH)) begin
			last_col_new = COL_W'(MAX_ROW_LENGTH - 1);
		end else begin
			last_col_new = COL_W'(len_raw - 1'b1);
		end
		if (32'(cnt_raw) < 32'(jfps_pkg::MIN_EXTENT)) begin
			last_row_new = RW'(jfps_pkg::MIN_EXTENT - 1);
		end else begin
			last_row_new = cnt_raw - 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_col_q <= COL_W'(LEN_RST - 1);
			last_row_q <= RW'(jfps_pkg::ROW_COUNT_RST - 1);
		end else if (wr_en) begin
			case (wr_index)
				jfps_pkg::REG_ROW_LENGTH: last_col_q <= last_col_new;
				jfps_pkg::REG_ROW_COUNT:  last_row_q <= last_row_new;
				default: ;
			endcase
		end
	end

	// raster position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (wr_en) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (row_q == last_row_q) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1  <= samples.sample;
			col_s1     <= col_q;
			produce_s1 <= (row_q >= RW'(2)) && (col_q >= COL_W'(2));
			last_s1    <= (row_q == last_row_q) && col_wrap;
		end
	end

	// row r-2 buffer: read on transfer, refill from row r-1 as the item leaves
	always_ff @(posedge clk) begin
		if (accept) begin
			older_rd_s1 <= older_mem[col_q];
		end
		if (advance_s1) begin
			older_mem[col_s1] <= prev_rd_s1;
		end
	end

	// row r-1 buffer: read on transfer, refill with the new sample
	always_ff @(posedge clk) begin
		if (accept) begin
			prev_rd_s1 <= prev_mem[col_q];
		end
		if (advance_s1) begin
			prev_mem[col_s1] <= sample_s1;
		end
	end

	// neighbour delay line
	always_ff @(posedge clk) begin
		if (advance_s1) begin
			north_q <= older_rd_s1;
			south_q <= sample_s1;
			mid2_q  <= mid1_q;
			mid1_q  <= prev_rd_s1;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// stencil: quarter of the four-neighbour sum
	always_ff @(posedge clk) begin
		if (advance_s1 && produce_s1) begin
			value_q <= jfps_pkg::quarter_sum(north_q, south_q, mid2_q, prev_rd_s1);
			last_q  <= last_s1;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.value        = value_q;
	assign results.last_of_grid = last_q;

`ifndef SYNTH
	// position never leaves the configured grid
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= last_col_q)
		else $error("column position beyond row length");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= last_row_q)
		else $error("row position beyond row count");

	// the last column of a row wraps to column zero
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col_wrap && !wr_en) |=> (col_q == '0))
		else $error("column counter failed to wrap");

	// a held read stage keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance_s1) |=> (valid_s1 && $stable(sample_s1)
			&& $stable(prev_rd_s1) && $stable(col_s1)))
		else $error("read stage lost its item while stalled");

	// a result is only made when the output register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && produce_s1) |-> (!out_valid_q || results.ready))
		else $error("output register overwritten");
`endif

endmodule

// ===== test/jfps_stencil_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfps_stencil_checker: scoreboard for the five-point stencil
// Watches register writes and both stream channels. Each sample transfer is
// run through a local model of the line buffers and raster position, and
// any interior point it completes is queued. Each result transfer is checked
// against the oldest queued point. Failures and queue depth go to the top.
// ----------------------------------------------------------------------------
module jfps_stencil_checker #(
	parameter int MAX_ROW_LENGTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	jfps_sample_if                        samples,
	jfps_result_if                        results,
	input  logic                          wr_en,
	input  jfps_pkg::reg_index_t          wr_index,
	input  logic [jfps_pkg::CFG_W-1:0]    wr_data,
	output int unsigned                   failures,
	output int unsigned                   pending
);

	localparam int DATA_W       = jfps_pkg::DATA_W;
	localparam int SUM_W        = jfps_pkg::SUM_W;
	localparam int ROW_LENGTH_W = jfps_pkg::ROW_LENGTH_W;
	localparam int ROW_COUNT_W  = jfps_pkg::ROW_COUNT_W;

	typedef struct packed {
		jfps_pkg::sample_t value;
		logic              last_of_grid;
	} interior_point_t;

	interior_point_t expected_points[$];

	// geometry registers as written
	logic [ROW_LENGTH_W-1:0] row_length_reg;
	logic [ROW_COUNT_W-1:0]  row_count_reg;

	// line buffers, raster position and stencil taps
	jfps_pkg::sample_t older_line[MAX_ROW_LENGTH];
	jfps_pkg::sample_t previous_line[MAX_ROW_LENGTH];
	int unsigned       column;
	int unsigned       row;
	jfps_pkg::sample_t north_tap;
	jfps_pkg::sample_t south_tap;
	jfps_pkg::sample_t center_tap;
	jfps_pkg::sample_t west_tap;

	// take one sample, queue the interior point it completes
	task automatic sweep_sample(input jfps_pkg::sample_t s);
		int unsigned       len;
		int unsigned       cnt;
		int unsigned       c;
		int unsigned       r;
		jfps_pkg::sample_t above_older;
		jfps_pkg::sample_t above_prev;
		jfps_pkg::sum_t    total;
		len = 32'(row_length_reg);
		if (len < jfps_pkg::MIN_EXTENT) len = jfps_pkg::MIN_EXTENT;
		if (len > MAX_ROW_LENGTH) len = MAX_ROW_LENGTH;
		cnt = 32'(row_count_reg);
		if (cnt < jfps_pkg::MIN_EXTENT) cnt = jfps_pkg::MIN_EXTENT;
		c = (column >= len) ? len - 1 : column;
		r = (row >= cnt) ? cnt - 1 : row;
		above_older = older_line[c];
		above_prev  = previous_line[c];
		// center is (r-1, c-1): north row r-2, south row r, west and east row r-1
		if (r >= 2 && c >= 2) begin
			total = {{2{north_tap[DATA_W-1]}}, north_tap} + {{2{south_tap[DATA_W-1]}}, south_tap}
				+ {{2{west_tap[DATA_W-1]}}, west_tap} + {{2{above_prev[DATA_W-1]}}, above_prev};
			expected_points.push_back('{value: total[SUM_W-1:2],
				last_of_grid: (r == cnt - 1 && c == len - 1)});
		end
		older_line[c]    = above_prev;
		previous_line[c] = s;
		north_tap  = above_older;
		south_tap  = s;
		west_tap   = center_tap;
		center_tap = above_prev;
		// raster advance with wrap at the end of the grid
		if (c + 1 >= len) begin
			column = 0;
			row    = (r + 1 >= cnt) ? 0 : r + 1;
		end else begin
			column = c + 1;
			row    = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		interior_point_t want;
		if (!arst_n) begin
			row_length_reg = ROW_LENGTH_W'(jfps_pkg::ROW_LENGTH_RST);
			row_count_reg  = ROW_COUNT_W'(jfps_pkg::ROW_COUNT_RST);
			for (int i = 0; i < MAX_ROW_LENGTH; i++) begin
				older_line[i]    = '0;
				previous_line[i] = '0;
			end
			column     = 0;
			row        = 0;
			north_tap  = '0;
			south_tap  = '0;
			center_tap = '0;
			west_tap   = '0;
			failures   = 0;
			expected_points.delete();
		end else begin
			// register write restarts the grid
			if (wr_en) begin
				if (wr_index == jfps_pkg::REG_ROW_LENGTH)
					row_length_reg = wr_data[ROW_LENGTH_W-1:0];
				else row_count_reg = wr_data[ROW_COUNT_W-1:0];
				column = 0;
				row    = 0;
			end
			// sample transfer
			if (samples.valid && samples.ready) sweep_sample(samples.sample);
			// result transfer
			if (results.valid && results.ready) begin
				if (expected_points.size() == 0) begin
					failures++;
					$error("value: expected none, actual %h", results.value);
				end else begin
					want = expected_points.pop_front();
					if (results.value !== want.value) begin
						failures++;
						$error("value: expected %h, actual %h", want.value, results.value);
					end
					if (results.last_of_grid !== want.last_of_grid) begin
						failures++;
						$error("last_of_grid: expected %b, actual %b",
							want.last_of_grid, results.last_of_grid);
					end
				end
			end
		end
		pending = expected_points.size();
	end

endmodule

// ===== test/jacobi_five_point_stencil_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_five_point_stencil_test: regression for the five-point stencil
// Streams grids of several geometries through the block, from the smallest
// 3 x 3 up to full-width rows, with random gaps on both channels, a long
// receiver hold-off and a stretch at full rate. Checking is done by the
// scoreboard beside the block; this top drives and reports the verdict.
// ----------------------------------------------------------------------------
module jacobi_five_point_stencil_test;

	localparam int      DATA_W          = jfps_pkg::DATA_W;
	localparam int      CFG_W           = jfps_pkg::CFG_W;
	localparam int      MAX_ROW_LENGTH  = 1024;
	localparam int      HOLD_OFF_CYCLES = 80;
	localparam int      DRAIN_CYCLES    = 6;
	localparam int      IDLE_PERCENT    = 38;
	localparam longint  TIMEOUT_NS      = 3_000_000;
	localparam jfps_pkg::sample_t SAMPLE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam jfps_pkg::sample_t SAMPLE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam jfps_pkg::sample_t ALL_ONES   = '1;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	jfps_pkg::reg_index_t   wr_index;
	logic [CFG_W-1:0]       wr_data;
	logic                   steady;
	logic                   hold_off_wanted;
	int unsigned            failures;
	int unsigned            pending;

	jfps_sample_if samples();
	jfps_result_if results();

	jacobi_five_point_stencil #(
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	jfps_stencil_checker #(
		.MAX_ROW_LENGTH (MAX_ROW_LENGTH)
	) u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.failures (failures),
		.pending  (pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("jacobi_five_point_stencil regression: fail");
		$finish;
	end

	// result receiver: random stalls, full rate when steady, one long hold-off
	initial begin
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_wanted) begin
				hold_off_wanted = 1'b0;
				for (int k = 0; k < HOLD_OFF_CYCLES; k++) begin
					results.ready <= 1'b0;
					@(negedge clk);
				end
			end
			results.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
		end
	end

	// grid value, biased toward the extremes
	function automatic jfps_pkg::sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			2: return ALL_ONES;
			3: return '0;
			default: return jfps_pkg::sample_t'($urandom());
		endcase
	endfunction

	// one sample transfer; called and returns at a falling edge
	task automatic send_sample(input jfps_pkg::sample_t s);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			samples.valid <= 1'b0;
			@(negedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= s;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// stop sending, wait out every expected result and the pipeline tail
	task automatic settle();
		samples.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// write both geometry registers on consecutive edges
	task automatic write_geometry(input int unsigned row_length, input int unsigned row_count);
		wr_en    <= 1'b1;
		wr_index <= jfps_pkg::REG_ROW_LENGTH;
		wr_data  <= CFG_W'(row_length);
		@(negedge clk);
		wr_index <= jfps_pkg::REG_ROW_COUNT;
		wr_data  <= CFG_W'(row_count);
		@(negedge clk);
		wr_en    <= 1'b0;
	endtask

	task automatic run_grid_phase(input int unsigned row_length, input int unsigned row_count,
		input int unsigned items);
		settle();
		write_geometry(row_length, row_count);
		repeat (items) send_sample(random_sample());
	endtask

	// stimulus
	initial begin
		arst_n          = 1'b0;
		samples.valid   = 1'b0;
		samples.sample  = '0;
		wr_en           = 1'b0;
		wr_index        = jfps_pkg::REG_ROW_LENGTH;
		wr_data         = '0;
		steady          = 1'b0;
		hold_off_wanted = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// both extents below the minimum act as a 3 x 3 grid
		write_geometry(0, 2);
		repeat (9) send_sample(SAMPLE_MAX);
		repeat (9) send_sample(SAMPLE_MIN);
		// north and south at max, west and east at min: sum -2 floors to -1
		for (int i = 0; i < 9; i++)
			send_sample((i == 1 || i == 7) ? SAMPLE_MAX :
				(i == 3 || i == 5) ? SAMPLE_MIN : ALL_ONES);

		run_grid_phase(5, 4, 80);

		// long receiver hold-off while samples keep coming, then a full drain at a grid boundary
		settle();
		write_geometry(7, 6);
		hold_off_wanted = 1'b1;
		repeat (84) send_sample(random_sample());
		settle();
		repeat (84) send_sample(random_sample());

		// tallest grid, left mid-grid by the next write
		run_grid_phase(3, 65535, 100);
		// row length clamps to the buffer size; too short for any result
		run_grid_phase(2047, 3, 50);
		run_grid_phase(3, 3, 90);

		// full rate on both sides
		steady = 1'b1;
		run_grid_phase(16, 5, 100);
		steady = 1'b0;

		// just over the buffer size, left within the first clamped row
		run_grid_phase(1025, 3, 40);
		run_grid_phase(4, 3, 60);

		settle();
		if (failures == 0) begin
			$display("jacobi_five_point_stencil regression: pass");
		end else begin
			$display("jacobi_five_point_stencil regression: fail");
		end
		$finish;
	end

endmodule
